// ===== sv/rpb_pkg.sv =====
// Shared types and constants for the Rocchio profile builder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package rpb_pkg;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 16;
  localparam int PEN_W   = 32;
  localparam int MARG_W  = 16;
  localparam int CFG_W   = 32;

  localparam int DIMS_DEFAULT     = 1024;
  localparam int MAX_DOCS_DEFAULT = 65535;

  // reset value of the zero margin, one LSB of Q16.16
  localparam logic [MARG_W-1:0] MARGIN_RESET = 16'd1;

  localparam logic [1:0] KIND_IN    = 2'd0;
  localparam logic [1:0] KIND_OUT   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic REG_PENALTY     = 1'b0;
  localparam logic REG_ZERO_MARGIN = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               carries_element;
    logic               doc_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] weight;
    logic        present;
  } out_item_t;

  // decoded operation handed from front to back
  typedef struct packed {
    logic               acc;       // add value into a sum
    logic               cls_out;   // out-of-class side
    logic               count;     // bump a document count
    logic               rd;        // weight read
    logic               rd_ok;     // read index within range
    logic               clr;       // clear everything
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } op_t;

endpackage
`default_nettype wire

// ===== sv/rocchio_profile_builder.sv =====
// Rocchio profile builder top level. A beat is decoded into the front-end queue and
// waits there until the back end takes it. Element beats hold the back end for a memory
// read, then add and write back; other accumulate-only beats for the count update.
// A read runs one 48-step divider pass, or with the penalty applied two passes, a multiply,
// subtract and compare; a read of an absent entry skips them; a waiting result stalls the next read.
// Reset and a clear beat sweep all min(DIMS,1024) memory entries; full stays high meanwhile.
`default_nettype none
module rocchio_profile_builder #(
  parameter int DIMS     = rpb_pkg::DIMS_DEFAULT,
  parameter int MAX_DOCS = rpb_pkg::MAX_DOCS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire rpb_pkg::in_item_t          item,
  output logic                            empty,
  input  wire logic                       pop,
  output rpb_pkg::out_item_t              result,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_index,
  input  wire logic [rpb_pkg::CFG_W-1:0]  cfg_data
);

  logic [rpb_pkg::PEN_W-1:0]  penalty;
  logic [rpb_pkg::MARG_W-1:0] zero_margin;
  logic                       q_valid;
  rpb_pkg::op_t               q_head;
  logic                       q_pop;
  logic                       clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      penalty     <= '0;
      zero_margin <= rpb_pkg::MARGIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rpb_pkg::REG_PENALTY:     penalty     <= cfg_data[rpb_pkg::PEN_W-1:0];
        rpb_pkg::REG_ZERO_MARGIN: zero_margin <= cfg_data[rpb_pkg::MARG_W-1:0];
        default: ;
      endcase
    end
  end

  rpb_front #(
    .DIMS (DIMS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .hold    (clearing),
    .full    (full),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  rpb_back #(
    .DIMS     (DIMS),
    .MAX_DOCS (MAX_DOCS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .penalty     (penalty),
    .zero_margin (zero_margin),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule
`default_nettype wire

// ===== sv/rpb_front.sv =====
// Front end: decodes incoming beats and holds them in a two-entry queue.
// Depends on rpb_pkg.
`default_nettype none
module rpb_front #(
  parameter int DIMS = rpb_pkg::DIMS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rpb_pkg::in_item_t item,
  input  wire logic             hold,
  output logic                  full,
  output logic                  q_valid,
  output rpb_pkg::op_t          q_head,
  input  wire logic             q_pop
);

  rpb_pkg::op_t fifo [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  rpb_pkg::op_t dec;
  logic         in_range;
  logic         is_elem_kind;
  logic         do_push;
  logic         do_pop;

  always_comb begin
    in_range     = 32'(item.index) < 32'(DIMS);
    is_elem_kind = (item.kind == rpb_pkg::KIND_IN) || (item.kind == rpb_pkg::KIND_OUT);
    dec.acc      = is_elem_kind && item.carries_element && in_range;
    dec.cls_out  = item.kind == rpb_pkg::KIND_OUT;
    dec.count    = is_elem_kind && item.doc_end;
    dec.rd       = item.kind == rpb_pkg::KIND_READ;
    dec.rd_ok    = in_range;
    dec.clr      = item.kind == rpb_pkg::KIND_CLEAR;
    dec.index    = item.index;
    dec.value    = item.value;
  end

  assign full    = (count == 2'd2) || hold;
  assign q_valid = count != 2'd0;
  assign q_head  = fifo[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== sv/rpb_div.sv =====
// Restoring divider, one quotient bit per cycle: sum / count.
// Depends on rpb_pkg.
`default_nettype none
module rpb_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rpb_pkg::SUM_W-1:0] dividend,
  input  wire logic [rpb_pkg::CNT_W-1:0] divisor,
  output logic                           done,
  output logic [rpb_pkg::SUM_W-1:0]      quotient
);

  localparam int SW = rpb_pkg::SUM_W;
  localparam int CW = rpb_pkg::CNT_W;
  localparam int NW = $clog2(SW);

  logic          busy;
  logic [NW-1:0] step;
  logic [SW-1:0] dq;
  logic [CW-1:0] dv;
  logic [CW-1:0] rem;
  logic [CW:0]   rem_sh;
  logic          fits;

  assign rem_sh   = {rem, dq[SW-1]};
  assign fits     = rem_sh >= {1'b0, dv};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dv  <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= CW'(rem_sh - {1'b0, dv});
      end else begin
        rem <= rem_sh[CW-1:0];
      end
      dq <= {dq[SW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == NW'(SW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/rpb_back.sv =====
// Back end: sum memories, document counts, read arithmetic, result register.
// Depends on rpb_pkg and rpb_div.
`default_nettype none
module rpb_back #(
  parameter int DIMS     = rpb_pkg::DIMS_DEFAULT,
  parameter int MAX_DOCS = rpb_pkg::MAX_DOCS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire rpb_pkg::op_t                q_head,
  output logic                             q_pop,
  output logic                             clearing,
  input  wire logic [rpb_pkg::PEN_W-1:0]   penalty,
  input  wire logic [rpb_pkg::MARG_W-1:0]  zero_margin,
  output logic                             empty,
  input  wire logic                        pop,
  output rpb_pkg::out_item_t               result
);

  localparam int SW        = rpb_pkg::SUM_W;
  localparam int CW        = rpb_pkg::CNT_W;
  localparam int MEM_DEPTH = DIMS < (2 ** rpb_pkg::INDEX_W) ? DIMS : (2 ** rpb_pkg::INDEX_W);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int CAP_INT   = MAX_DOCS < 65535 ? MAX_DOCS : 65535;
  localparam logic [CW-1:0] COUNT_CAP = CW'(CAP_INT);
  localparam int PW        = 57;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ACC, ST_RDMEM, ST_DIV_IN, ST_DIV_OUT,
    ST_MUL_LO, ST_MUL_HI, ST_SUB, ST_JUDGE, ST_PUSH
  } state_t;

  state_t state;

  // entry = {seen, sum}
  logic [SW:0] in_mem  [MEM_DEPTH];
  logic [SW:0] out_mem [MEM_DEPTH];
  logic [SW:0] in_rd;
  logic [SW:0] out_rd;
  logic [SW:0] out_ent;

  logic [AW-1:0] sweep;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          in_we;
  logic          out_we;
  logic [SW:0]   wdata;
  logic [SW:0]   acc_src;
  logic [SW:0]   acc_sum;

  rpb_pkg::op_t cur;
  logic [CW-1:0] in_cnt;
  logic [CW-1:0] out_cnt;
  logic          apply;

  logic          div_start;
  logic [SW-1:0] div_a;
  logic [CW-1:0] div_b;
  logic          div_done;
  logic [SW-1:0] div_q;

  logic [SW-1:0] mean_in;
  logic [SW-1:0] mean_out;
  logic [23:0]   mul_b;
  logic [55:0]   mul_p;
  logic [55:0]   prod_lo;
  logic [55:0]   prod_hi;
  logic [PW-1:0] sub;
  logic [PW-1:0] mean_x;
  logic [PW-1:0] diff;

  rpb_pkg::out_item_t res;
  logic               out_valid;

  rpb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign clearing = state == ST_CLEAR;
  assign empty    = !out_valid;
  assign raddr    = q_head.index[AW-1:0];

  // accumulate write or clearing sweep
  always_comb begin
    acc_src = cur.cls_out ? out_rd : in_rd;
    acc_sum = {1'b0, acc_src[SW-1:0]} + (SW + 1)'(cur.value);
    if (state == ST_CLEAR) begin
      waddr  = sweep;
      wdata  = '0;
      in_we  = 1'b1;
      out_we = 1'b1;
    end else begin
      waddr  = cur.index[AW-1:0];
      wdata  = {1'b1, acc_sum[SW] ? {SW{1'b1}} : acc_sum[SW-1:0]};
      in_we  = (state == ST_ACC) && !cur.cls_out;
      out_we = (state == ST_ACC) && cur.cls_out;
    end
  end

  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem[waddr] <= wdata;
    end
    in_rd <= in_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[waddr] <= wdata;
    end
    out_rd <= out_mem[raddr];
  end

  // one shared 32x24 multiplier for both halves of mean_out
  assign mul_b  = (state == ST_MUL_LO) ? mean_out[23:0] : mean_out[47:24];
  assign mul_p  = 56'(penalty) * 56'(mul_b);
  assign mean_x = PW'(mean_in);
  assign diff   = mean_x - sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      in_cnt    <= '0;
      out_cnt   <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(MEM_DEPTH - 1)) begin
            sweep <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_head;
            if (q_head.clr) begin
              in_cnt  <= '0;
              out_cnt <= '0;
              state   <= ST_CLEAR;
            end else if (q_head.rd) begin
              state <= ST_RDMEM;
            end else begin
              if (q_head.count) begin
                if (q_head.cls_out) begin
                  out_cnt <= (out_cnt < COUNT_CAP) ? out_cnt + 1'b1 : COUNT_CAP;
                end else begin
                  in_cnt <= (in_cnt < COUNT_CAP) ? in_cnt + 1'b1 : COUNT_CAP;
                end
              end
              if (q_head.acc) begin
                state <= ST_ACC;
              end
            end
          end
        end
        ST_ACC: begin
          state <= ST_IDLE;
        end
        ST_RDMEM: begin
          out_ent <= out_rd;
          apply   <= (penalty != '0) && (out_cnt != '0) && out_rd[SW];
          if (cur.rd_ok && (in_cnt != '0) && in_rd[SW]) begin
            div_a     <= in_rd[SW-1:0];
            div_b     <= in_cnt;
            div_start <= 1'b1;
            state     <= ST_DIV_IN;
          end else begin
            res   <= '0;
            state <= ST_PUSH;
          end
        end
        ST_DIV_IN: begin
          if (div_done) begin
            mean_in <= div_q;
            if (apply) begin
              div_a     <= out_ent[SW-1:0];
              div_b     <= out_cnt;
              div_start <= 1'b1;
              state     <= ST_DIV_OUT;
            end else begin
              res.weight  <= (|div_q[SW-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
              res.present <= 1'b1;
              state       <= ST_PUSH;
            end
          end
        end
        ST_DIV_OUT: begin
          if (div_done) begin
            mean_out <= div_q;
            state    <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          prod_lo <= mul_p;
          state   <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          prod_hi <= mul_p;
          state   <= ST_SUB;
        end
        ST_SUB: begin
          sub   <= PW'(prod_hi) + PW'(prod_lo[55:24]);
          state <= ST_JUDGE;
        end
        ST_JUDGE: begin
          if ((mean_x <= sub) || (diff <= PW'(zero_margin))) begin
            res <= '0;
          end else begin
            res.weight  <= (|diff[PW-1:32]) ? 32'hFFFF_FFFF : diff[31:0];
            res.present <= 1'b1;
          end
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            result    <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

endmodule
`default_nettype wire
